>>> hw/rtl/fsk_tone_frame_transmitter_top_assert.svh
// Assertion macros for the FSK tone frame transmitter.
`ifndef FSK_TONE_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define FSK_TONE_FRAME_TRANSMITTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, held off while reset is asserted.
`define FSKTX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication check, held off while reset is asserted.
`define FSKTX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FSKTX_ASSERT(lbl, prop, msg)
`define FSKTX_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/fsktx_pkg.sv
// Types, codes and sine table builder for the FSK tone frame transmitter.
package fsktx_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_ABORT = 2'd3;

  localparam logic [1:0] CFG_TONE_ZERO_STEP  = 2'd0;
  localparam logic [1:0] CFG_TONE_ONE_STEP   = 2'd1;
  localparam logic [1:0] CFG_SAMPLES_PER_BIT = 2'd2;
  localparam logic [1:0] CFG_AMPLITUDE       = 2'd3;

  localparam logic [31:0] TONE_ZERO_STEP_RST  = 32'd1928352663;
  localparam logic [31:0] TONE_ONE_STEP_RST   = 32'd1967309477;
  localparam logic [12:0] SAMPLES_PER_BIT_RST = 13'd5512;
  localparam logic [14:0] AMPLITUDE_RST       = 15'd24000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    SEC_IDLE     = 4'b0001,
    SEC_PREAMBLE = 4'b0010,
    SEC_LENGTH   = 4'b0100,
    SEC_DATA     = 4'b1000
  } sec_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic [7:0] message_length;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sending;
    logic               current_bit;
    logic               frame_end;
    logic [31:0]        bits_sent;
  } out_t;

  // Q15 quarter-wave sine entry i of a table with 2^bits steps (Q30 Taylor sum).
  function automatic logic [14:0] quarter_sine(input int unsigned i, input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (64'(i) * HALF_PI_Q30) >> bits;
    term = x;
    sum  = $signed(x);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd6;
    sum  = sum - $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd20;
    sum  = sum + $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd42;
    sum  = sum - $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd72;
    sum  = sum + $signed(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

>>> hw/rtl/fsktx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsktx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/fsk_tone_frame_transmitter_top.sv
// Top level of the binary FSK tone frame transmitter.
//
// Input channel (in_valid/in_ready/in_data) carries one command per transaction:
// tick (one audio sample), load (write a message byte), start (open a frame with a
// length) or abort (end the frame at a byte boundary past the preamble). Every accepted
// transaction gives exactly one result on the output channel (out_valid/out_ready/
// out_data): the sample, sending and bit flags, frame end marker and bit count.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready and writes the tone steps, samples per bit and amplitude.
//
// Throughput is one transaction per cycle while the receiver takes results; each
// result is registered on acceptance. The rate is set by the sine table register,
// which is addressed from the next phase value, and by the single multiply by
// amplitude that feeds the result register. Message bytes are fetched ahead into a
// lookahead byte so the memory read never sits in the sample path.
//
// Reset returns the control state and configuration registers to their defaults;
// the message memory is not cleared and needs no clearing pass. When the receiver
// stalls, the result register holds and in_ready drops until the result is taken.
module fsk_tone_frame_transmitter_top
  import fsktx_pkg::*;
#(
  parameter int MESSAGE_DEPTH   = 256,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "fsk_tone_frame_transmitter_top_assert.svh"

  localparam int MSG_AW = $clog2(MESSAGE_DEPTH);
  localparam int TAB_N  = 1 << SINE_TABLE_BITS;
  localparam int TAB_AW = SINE_TABLE_BITS + 1;

  // Configuration registers
  logic [PHASE_BITS-1:0] zero_step_r, one_step_r;
  logic [12:0]           spb_r;
  logic [14:0]           amp_r;

  // Frame state
  sec_t                  sec_r, sec_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt, phase_eff;
  logic [12:0]           sib_r, sib_nxt;
  logic [2:0]            bib_r, bib_nxt;
  logic [7:0]            bpos_r, bpos_nxt;
  logic [7:0]            len_r, len_nxt;
  logic [31:0]           done_r, done_nxt;
  logic                  abort_r, abort_nxt;
  logic [7:0]            cbyte_r, cbyte_nxt;
  logic [7:0]            ahead_r, ahead_nxt;

  // Last memory write, for the lookahead bypass
  logic                  wprev_r;
  logic [MSG_AW-1:0]     wprev_addr_r;
  logic [7:0]            wprev_data_r;

  logic                  out_valid_r;
  out_t                  out_data_r, res;

  logic                  in_fire;
  logic                  idx_ok, ahead_ok, ram_we;
  logic [7:0]            ram_rdata, nb_eff;
  logic                  bit_val;
  logic [PHASE_BITS-1:0] step;
  logic [12:0]           sib_inc, limit;
  logic                  end_bit, frame_done;

  logic [14:0]           sine_tab [TAB_N+1];
  logic [14:0]           sine_r;
  logic [TAB_AW-1:0]     rom_idx;
  logic [SINE_TABLE_BITS-1:0] rom_j;
  logic [29:0]           prod;
  logic [15:0]           mag;
  logic [15:0]           smp;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_step_r <= TONE_ZERO_STEP_RST[PHASE_BITS-1:0];
      one_step_r  <= TONE_ONE_STEP_RST[PHASE_BITS-1:0];
      spb_r       <= SAMPLES_PER_BIT_RST;
      amp_r       <= AMPLITUDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TONE_ZERO_STEP:  zero_step_r <= cfg_data[PHASE_BITS-1:0];
        CFG_TONE_ONE_STEP:   one_step_r  <= cfg_data[PHASE_BITS-1:0];
        CFG_SAMPLES_PER_BIT: spb_r       <= cfg_data[12:0];
        CFG_AMPLITUDE:       amp_r       <= cfg_data[14:0];
      endcase
    end
  end

  // Quarter-wave sine table, built at elaboration
  for (genvar g = 0; g <= TAB_N; g++) begin : g_sine
    localparam logic [14:0] ENTRY = quarter_sine(g, SINE_TABLE_BITS);
    assign sine_tab[g] = ENTRY;
  end

  // Address the table from the phase that the state register is about to hold
  assign phase_eff = rst_n ? phase_nxt : '0;
  assign rom_j     = phase_eff[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_idx   = phase_eff[PHASE_BITS-2] ? (TAB_AW'(TAB_N) - {1'b0, rom_j})
                                             : {1'b0, rom_j};

  always_ff @(posedge clk) begin
    sine_r <= sine_tab[rom_idx];
  end

  assign prod = sine_r * amp_r;
  assign mag  = {1'b0, prod[29:15]};
  assign smp  = phase_r[PHASE_BITS-1] ? (16'd0 - mag) : mag;

  // Message memory and lookahead byte
  assign idx_ok   = {1'b0, in_data.byte_index} < 9'(MESSAGE_DEPTH);
  assign ahead_ok = {1'b0, ahead_r} < 9'(MESSAGE_DEPTH);

  fsktx_ram #(
    .WIDTH (8),
    .DEPTH (MESSAGE_DEPTH)
  ) u_msg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.byte_index[MSG_AW-1:0]),
    .wdata (in_data.byte_value),
    .raddr (ahead_r[MSG_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (!ahead_ok) begin
      nb_eff = 8'd0;
    end else if (wprev_r && (wprev_addr_r == ahead_r[MSG_AW-1:0])) begin
      nb_eff = wprev_data_r;
    end else begin
      nb_eff = ram_rdata;
    end
  end

  always_comb begin
    unique case (sec_r)
      SEC_PREAMBLE: bit_val = bib_r[0];
      SEC_LENGTH:   bit_val = len_r[~bib_r];
      SEC_DATA:     bit_val = cbyte_r[~bib_r];
      default:      bit_val = 1'b0;
    endcase
  end

  assign step    = bit_val ? one_step_r : zero_step_r;
  assign sib_inc = sib_r + 13'd1;
  assign limit   = (spb_r == 13'd0) ? 13'd1 : spb_r;
  assign end_bit = (sib_inc >= limit) || (sib_inc == 13'd0);

  always_comb begin
    sec_nxt    = sec_r;
    phase_nxt  = phase_r;
    sib_nxt    = sib_r;
    bib_nxt    = bib_r;
    bpos_nxt   = bpos_r;
    len_nxt    = len_r;
    done_nxt   = done_r;
    abort_nxt  = abort_r;
    cbyte_nxt  = cbyte_r;
    ram_we     = 1'b0;
    frame_done = 1'b0;
    res        = '0;
    if (in_fire) begin
      unique case (in_data.opcode)
        OP_LOAD: begin
          ram_we = idx_ok;
          // Keep the byte in flight current with late writes
          if (idx_ok && (sec_r == SEC_DATA) && (in_data.byte_index == bpos_r)) begin
            cbyte_nxt = in_data.byte_value;
          end
          res.sending = (sec_r != SEC_IDLE);
        end
        OP_START: begin
          if (sec_r == SEC_IDLE) begin
            len_nxt   = in_data.message_length;
            sec_nxt   = SEC_PREAMBLE;
            phase_nxt = '0;
            sib_nxt   = '0;
            bib_nxt   = '0;
            bpos_nxt  = '0;
            abort_nxt = 1'b0;
          end
          res.sending = 1'b1;
        end
        OP_ABORT: begin
          if (sec_r != SEC_IDLE) begin
            abort_nxt = 1'b1;
          end
          res.sending = (sec_r != SEC_IDLE);
        end
        OP_TICK: begin
          if (sec_r != SEC_IDLE) begin
            res.sample      = $signed(smp);
            res.sending     = 1'b1;
            res.current_bit = bit_val;
            phase_nxt       = phase_r + step;
            sib_nxt         = sib_inc;
            if (end_bit) begin
              done_nxt  = done_r + 32'd1;
              phase_nxt = '0;
              sib_nxt   = '0;
              bib_nxt   = bib_r + 3'd1;
              if (bib_r == 3'd7) begin
                unique case (sec_r)
                  SEC_PREAMBLE: sec_nxt = SEC_LENGTH;
                  SEC_LENGTH: begin
                    if ((len_r == 8'd0) || abort_r) begin
                      frame_done = 1'b1;
                    end else begin
                      sec_nxt   = SEC_DATA;
                      bpos_nxt  = '0;
                      cbyte_nxt = nb_eff;
                    end
                  end
                  SEC_DATA: begin
                    bpos_nxt = bpos_r + 8'd1;
                    if ((bpos_nxt >= len_r) || (bpos_nxt == 8'd0) || abort_r) begin
                      frame_done = 1'b1;
                    end else begin
                      cbyte_nxt = nb_eff;
                    end
                  end
                  default: frame_done = 1'b1;
                endcase
              end
            end
            if (frame_done) begin
              sec_nxt       = SEC_IDLE;
              abort_nxt     = 1'b0;
              bpos_nxt      = '0;
              res.frame_end = 1'b1;
            end
          end
        end
      endcase
    end
    res.bits_sent = done_nxt;
  end

  // Lookahead points at the next data byte to be sent
  assign ahead_nxt = (sec_nxt == SEC_DATA) ? (bpos_nxt + 8'd1) : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= SEC_IDLE;
      phase_r     <= '0;
      sib_r       <= '0;
      bib_r       <= '0;
      bpos_r      <= '0;
      len_r       <= '0;
      done_r      <= '0;
      abort_r     <= 1'b0;
      ahead_r     <= '0;
      wprev_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sec_r       <= sec_nxt;
      phase_r     <= phase_nxt;
      sib_r       <= sib_nxt;
      bib_r       <= bib_nxt;
      bpos_r      <= bpos_nxt;
      len_r       <= len_nxt;
      done_r      <= done_nxt;
      abort_r     <= abort_nxt;
      ahead_r     <= ahead_nxt;
      wprev_r     <= ram_we;
      out_valid_r <= in_fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    cbyte_r      <= cbyte_nxt;
    wprev_addr_r <= in_data.byte_index[MSG_AW-1:0];
    wprev_data_r <= in_data.byte_value;
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  `FSKTX_ASSERT_IMP(a_idle_no_abort, sec_r == SEC_IDLE, !abort_r, "abort pending while idle")
  `FSKTX_ASSERT_IMP(a_idle_counters, sec_r == SEC_IDLE,
    (sib_r == 13'd0) && (bib_r == 3'd0) && (phase_r == '0), "bit counters not cleared when idle")
  `FSKTX_ASSERT_IMP(a_bits_step, $past(rst_n),
    (done_r == $past(done_r)) || (done_r == $past(done_r) + 32'd1), "bit count jumped")
  `FSKTX_ASSERT(a_nontick_silent,
    (in_fire && (in_data.opcode != OP_TICK)) |=> (out_data_r.sample == 16'sd0),
    "non-tick transaction produced a sample")

endmodule

>>> bench/tb_fsk_tone_frame_transmitter_top.sv
// Testbench for the FSK tone frame transmitter: queued commands, predicted samples, checked results.
`timescale 1ns / 1ps

module tb_fsk_tone_frame_transmitter_top;
  import fsktx_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fsk_tone_frame_transmitter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transmitter shadow: registers, frame state, sine table.
  logic [31:0] reg_zero_step = TONE_ZERO_STEP_RST;
  logic [31:0] reg_one_step  = TONE_ONE_STEP_RST;
  logic [12:0] reg_spb       = SAMPLES_PER_BIT_RST;
  logic [14:0] reg_amp       = AMPLITUDE_RST;

  logic [7:0]  tx_store [0:255];
  logic [31:0] tx_phase = '0;
  logic [12:0] tx_sib = '0;
  logic [2:0]  tx_bib = '0;
  logic [7:0]  tx_pos = '0;
  sec_t        tx_section = SEC_IDLE;
  logic [7:0]  tx_len = '0;
  logic [31:0] tx_bits = '0;
  bit          tx_abort = 1'b0;
  logic [15:0] sine_q [0:1024];

  in_t  pending_cmds[$];
  out_t predicted_outputs[$];
  bit   store_loaded [0:255];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  int   err_count = 0;

  task automatic note_mismatch(string msg);
    err_count++;
    if (err_count <= 50) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Q15 quarter-wave entry from a Q30 Taylor series through x^11.
  function automatic logic [15:0] sine_entry(int unsigned i);
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint unsigned div;
    longint          sum;
    x = i;
    x = (x * 64'd1686629713) >> 10;
    term = x;
    sum = $signed(x);
    for (int k = 1; k <= 5; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      div = 2 * k * (2 * k + 1);
      term = term / div;
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[15:0];
  endfunction

  function automatic logic [15:0] tone_value(logic [31:0] ph);
    logic [11:0] addr;
    logic [1:0]  quad;
    int unsigned pick;
    logic [31:0] mag;
    addr = ph[31:20];
    quad = addr[11:10];
    pick = quad[0] ? (1024 - addr[9:0]) : addr[9:0];
    mag = (32'(sine_q[pick]) * 32'(reg_amp)) >> 15;
    return quad[1] ? -mag[15:0] : mag[15:0];
  endfunction

  function automatic logic frame_bit();
    case (tx_section)
      SEC_PREAMBLE: return tx_bib[0];
      SEC_LENGTH:   return tx_len[3'd7 - tx_bib];
      default:      return tx_store[tx_pos][3'd7 - tx_bib];
    endcase
  endfunction

  // Advance to the next byte; true when the frame closes here.
  function automatic bit finish_byte();
    if (tx_section == SEC_PREAMBLE) begin
      tx_section = SEC_LENGTH;
      return 1'b0;
    end
    if (tx_section == SEC_LENGTH) begin
      if (tx_len == 0 || tx_abort) return 1'b1;
      tx_section = SEC_DATA;
      tx_pos = '0;
      return 1'b0;
    end
    tx_pos = tx_pos + 8'd1;
    return (tx_pos >= tx_len) || (tx_pos == 0) || tx_abort;
  endfunction

  function automatic out_t step_transmitter(in_t cmd);
    out_t        r;
    logic [12:0] lim;
    r = '0;
    case (cmd.opcode)
      OP_LOAD: begin
        tx_store[cmd.byte_index] = cmd.byte_value;
        r.sending = (tx_section != SEC_IDLE);
      end
      OP_START: begin
        if (tx_section == SEC_IDLE) begin
          tx_len = cmd.message_length;
          tx_section = SEC_PREAMBLE;
          tx_phase = '0;
          tx_sib = '0;
          tx_bib = '0;
          tx_pos = '0;
          tx_abort = 1'b0;
        end
        r.sending = 1'b1;
      end
      OP_ABORT: begin
        if (tx_section != SEC_IDLE) tx_abort = 1'b1;
        r.sending = (tx_section != SEC_IDLE);
      end
      default: begin
        if (tx_section != SEC_IDLE) begin
          lim = (reg_spb == 0) ? 13'd1 : reg_spb;
          r.current_bit = frame_bit();
          r.sending = 1'b1;
          r.sample = tone_value(tx_phase);
          tx_phase = tx_phase + (r.current_bit ? reg_one_step : reg_zero_step);
          tx_sib = tx_sib + 13'd1;
          if (tx_sib >= lim || tx_sib == 0) begin
            tx_bits = tx_bits + 32'd1;
            tx_phase = '0;
            tx_sib = '0;
            tx_bib = tx_bib + 3'd1;
            if (tx_bib == 0 && finish_byte()) begin
              tx_section = SEC_IDLE;
              tx_abort = 1'b0;
              tx_pos = '0;
              r.frame_end = 1'b1;
            end
          end
        end
      end
    endcase
    r.bits_sent = tx_bits;
    return r;
  endfunction

  // Command queue builders.
  function automatic void push_cmd(logic [1:0] op, logic [7:0] idx, logic [7:0] val,
                                   logic [7:0] len);
    in_t c;
    c.opcode = op;
    c.byte_index = idx;
    c.byte_value = val;
    c.message_length = len;
    if (op == OP_LOAD) store_loaded[idx] = 1'b1;
    pending_cmds.push_back(c);
  endfunction

  function automatic void push_ticks(int n);
    repeat (n) push_cmd(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic void push_abort();
    push_cmd(OP_ABORT, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Load any of the first `need` bytes that were never written, then start.
  function automatic void push_start(int len, int need);
    for (int i = 0; i < need && i < 256; i++) begin
      if (!store_loaded[i]) push_cmd(OP_LOAD, 8'(i), 8'($urandom), 8'($urandom));
    end
    push_cmd(OP_START, 8'($urandom), 8'($urandom), 8'(len));
  endfunction

  function automatic void push_noise();
    int len;
    case ($urandom_range(3))
      0: push_ticks(1);
      1: push_cmd(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      2: begin
        len = $urandom_range(0, 20);
        push_start(len, len + 1);
      end
      default: push_abort();
    endcase
  endfunction

  function automatic void push_frame(int spb);
    int len;
    int ticks;
    int abort_at;
    repeat ($urandom_range(0, 3)) push_cmd(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
    len = ($urandom_range(9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
    push_start(len, len + 1);
    ticks = (16 + 8 * len) * spb + $urandom_range(0, 4);
    abort_at = ($urandom_range(3) == 0) ? $urandom_range(0, ticks - 1) : -1;
    for (int t = 0; t < ticks; t++) begin
      if (t == abort_at) push_abort();
      if ($urandom_range(39) == 0) push_noise();
      push_ticks(1);
    end
  endfunction

  // Input driver: hold a stalled transaction, otherwise offer the next command.
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_outputs.push_back(step_transmitter(in_data));
      if (!(in_valid && !in_ready)) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted transaction with the oldest prediction.
  always @(posedge clk) begin : monitor
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outputs.size() == 0) begin
          note_mismatch($sformatf("result with nothing predicted: %h", out_data));
        end else begin
          want = predicted_outputs.pop_front();
          if (out_data.sample !== want.sample)
            note_mismatch($sformatf("sample %0d, want %0d", out_data.sample, want.sample));
          if (out_data.sending !== want.sending)
            note_mismatch($sformatf("sending %b, want %b", out_data.sending, want.sending));
          if (out_data.current_bit !== want.current_bit)
            note_mismatch($sformatf("current_bit %b, want %b", out_data.current_bit,
                                    want.current_bit));
          if (out_data.frame_end !== want.frame_end)
            note_mismatch($sformatf("frame_end %b, want %b", out_data.frame_end,
                                    want.frame_end));
          if (out_data.bits_sent !== want.bits_sent)
            note_mismatch($sformatf("bits_sent %0d, want %0d", out_data.bits_sent,
                                    want.bits_sent));
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic hold_receiver(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TONE_ZERO_STEP:  reg_zero_step = value;
      CFG_TONE_ONE_STEP:   reg_one_step = value;
      CFG_SAMPLES_PER_BIT: reg_spb = value[12:0];
      default:             reg_amp = value[14:0];
    endcase
  endtask

  // Wait until every command is accepted and every result checked.
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || predicted_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : sequencer
    int spb;
    for (int i = 0; i <= 1024; i++) sine_q[i] = sine_entry(i);
    for (int i = 0; i < 256; i++) begin
      tx_store[i] = '0;
      store_loaded[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: idle tick, idle abort, loads at both ends, a frame under way.
    push_ticks(1);
    push_abort();
    push_cmd(OP_LOAD, 8'd255, 8'h5A, 8'h00);
    push_cmd(OP_LOAD, 8'd0, 8'hA5, 8'hFF);
    push_cmd(OP_LOAD, 8'd1, 8'hFF, 8'h00);
    push_cmd(OP_LOAD, 8'd2, 8'h00, 8'hFF);
    push_start(2, 3);
    push_ticks(12);
    drain();

    // Extreme steps and amplitude; samples_per_bit drops below the count mid-bit.
    send_idle_pct = 34;
    recv_stall_pct = 34;
    write_reg(CFG_TONE_ZERO_STEP, 32'h0000_0000);
    write_reg(CFG_TONE_ONE_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_SAMPLES_PER_BIT, 32'd1);
    write_reg(CFG_AMPLITUDE, 32'd32767);
    push_ticks(36);
    push_start(0, 1);
    push_ticks(18);
    // Load and start during a frame.
    push_start(3, 4);
    push_ticks(5);
    push_cmd(OP_LOAD, 8'd2, 8'hC3, 8'h00);
    push_start(9, 10);
    push_ticks(44);
    // Abort in the length byte of a maximum-length frame.
    push_start(255, 1);
    push_ticks(10);
    push_abort();
    push_ticks(10);
    // Abort inside the first data byte.
    push_start(3, 4);
    push_ticks(20);
    push_abort();
    push_ticks(10);
    drain();

    // Long bit at the largest samples_per_bit, then a zero samples_per_bit cuts it short.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_TONE_ZERO_STEP, 32'h1234_5678);
    write_reg(CFG_TONE_ONE_STEP, 32'h8000_0001);
    write_reg(CFG_SAMPLES_PER_BIT, 32'd8191);
    push_start(0, 1);
    push_ticks(200);
    drain();
    write_reg(CFG_SAMPLES_PER_BIT, 32'd0);
    write_reg(CFG_AMPLITUDE, 32'd0);
    push_ticks(20);
    drain();

    // Random frames under each idling pattern; the last holds off the receiver.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        3: begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      spb = (p == 0) ? 1 : $urandom_range(1, 4);
      write_reg(CFG_TONE_ZERO_STEP, $urandom);
      write_reg(CFG_TONE_ONE_STEP, $urandom);
      write_reg(CFG_SAMPLES_PER_BIT, 32'(spb));
      write_reg(CFG_AMPLITUDE, (p == 1) ? 32'd32767 : 32'($urandom_range(0, 32767)));
      if (p == 4) fork
        hold_receiver(400);
      join_none
      while (pending_cmds.size() < 180) push_frame(spb);
      drain();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
